### rtl/core/set_assoc_cache_lru_tracker_top_defines.svh
// Assertion macros for the tracker RTL.
// No dependencies.
`ifndef SET_ASSOC_CACHE_LRU_TRACKER_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_TRACKER_TOP_DEFINES_SVH
// implication check, disabled in reset
`define SALT_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// next-cycle implication check
`define SALT_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

### rtl/core/salt_pkg.sv
// Package: types and constants for the cache LRU tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package salt_pkg;
	localparam int MAX_SETS_D = 64;
	localparam int MAX_WAYS_D = 8;
	localparam logic [1:0] FUNC_FETCH  = 2'd0;
	localparam logic [1:0] FUNC_MODIFY = 2'd3;
	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_BLK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS     = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] mem_address;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  hits_added;
		logic        was_miss;
		logic        was_eviction;
		logic [31:0] total_hits;
		logic [31:0] total_misses;
		logic [31:0] total_evictions;
	} out_word_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_WRITE,
		BK_CLEAR
	} bk_state_t;
endpackage
`default_nettype wire

### rtl/core/set_assoc_cache_lru_tracker_top.sv
// Usage: set-associative cache LRU tracker, top level.
// Channels: input word {func, mem_address} enters on push when full is low.
// Result word {hits_added, was_miss, was_eviction, totals} is shown while
// empty is low and leaves on pop. One result per input word, in order.
// Config: cfg_we with cfg_index (0 set bits, 1 block bits, 2 ways) and cfg_data
// are to be written by the user only while the block is idle; not enforced.
// Path: a word passes a 2-entry front queue; the back end takes it in IDLE and
// issues the set row read, holds the read in READ, then in WRITE resolves it,
// writes the row back unless func is fetch, and registers the result word.
// The back end takes no new word until the previous one has passed READ and
// WRITE and its result word has been popped.
// Reset: counters, recency clock and config return to defaults; the back end
// then clears all 1 << SW RAM rows (64 by default), one a cycle, while
// input words queue but are not processed.
// Stall: when the result register holds an unpopped word the back end waits;
// the front queue keeps accepting until it holds two words, then full rises.
// Depends on salt_pkg, salt_front, salt_back.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_tracker_top
	import salt_pkg::*;
#(
	parameter int MAX_SETS = MAX_SETS_D,
	parameter int MAX_WAYS = MAX_WAYS_D
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire in_word_t  in_word,
	output logic           empty,
	input  wire logic      pop,
	output out_word_t      out_word,
	input  wire logic      cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data
);
	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

	logic [2:0] set_bits_q;
	logic [4:0] blk_bits_q;
	logic [3:0] ways_q;
	logic       q_valid, q_take, res_valid;
	logic [1:0] q_func;
	logic [63:0] q_tag;
	logic [SW-1:0] q_set;
	logic [$clog2(MAX_SETS)-1:0] q_set_f;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= '0;
			blk_bits_q <= '0;
			ways_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_BITS: set_bits_q <= cfg_data[2:0];
				REG_BLK_BITS: blk_bits_q <= cfg_data;
				REG_WAYS:     ways_q <= cfg_data[3:0];
				default:      ;
			endcase
		end
	end

	salt_front #(.MAX_SETS(MAX_SETS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.set_index_bits(set_bits_q), .block_offset_bits(blk_bits_q),
		.q_valid(q_valid), .q_func(q_func), .q_set(q_set_f), .q_tag(q_tag),
		.q_take(q_take)
	);

	assign q_set = SW'(q_set_f);

	salt_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_func(q_func),
		.q_set(q_set), .q_tag(q_tag), .q_take(q_take), .ways_in_use(ways_q),
		.res_valid(res_valid), .res_word(out_word), .res_take(pop)
	);

	assign empty = !res_valid;
endmodule
`default_nettype wire

### rtl/core/salt_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module salt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/salt_front.sv
// Front end: accepts accesses, splits address into set and tag, queues them.
// Depends on salt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salt_front
	import salt_pkg::*;
#(
	parameter int MAX_SETS = MAX_SETS_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire in_word_t    in_word,
	input  wire logic [2:0]  set_index_bits,
	input  wire logic [4:0]  block_offset_bits,
	output logic             q_valid,
	output logic [1:0]       q_func,
	output logic [$clog2(MAX_SETS)-1:0] q_set,
	output logic [63:0]      q_tag,
	input  wire logic        q_take
);
	localparam int SW = $clog2(MAX_SETS);
	localparam int SB = (SW < 1) ? 1 : SW;
	// largest set bit count whose set count fits in MAX_SETS
	localparam int MAXS = $clog2(MAX_SETS + 1) - 1;

	// two-entry queue
	logic [1:0]  f_func_q [2];
	logic [SB-1:0] f_set_q [2];
	logic [63:0] f_tag_q [2];
	logic [1:0]  cnt_q;
	logic        rd_q, wr_q;
	logic [2:0]  s_eff;
	logic [63:0] shifted;
	logic [63:0] set_mask;
	logic [63:0] tag_c;
	logic        do_push, do_pop;

	always_comb begin
		s_eff = (int'(set_index_bits) > MAXS) ? 3'(MAXS) : set_index_bits;
		shifted = in_word.mem_address >> block_offset_bits;
		set_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << s_eff);
		tag_c = shifted >> s_eff;
	end

	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop = q_take && q_valid;
	assign q_valid = (cnt_q != 2'd0);
	assign q_func = f_func_q[rd_q];
	assign q_tag = f_tag_q[rd_q];

	generate
		if (SW == 0) begin : g_one
			assign q_set = '0;
		end else begin : g_many
			assign q_set = f_set_q[rd_q][SW-1:0];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (do_push) begin
			f_func_q[wr_q] <= in_word.func;
			f_set_q[wr_q] <= SB'(shifted & set_mask);
			f_tag_q[wr_q] <= tag_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule
`default_nettype wire

### rtl/core/salt_back.sv
// Back end: clears set state, reads one set, resolves hit/fill/evict, writes back.
// Depends on salt_pkg, salt_ram and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_lru_tracker_top_defines.svh"
module salt_back
	import salt_pkg::*;
#(
	parameter int MAX_SETS = MAX_SETS_D,
	parameter int MAX_WAYS = MAX_WAYS_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire logic [1:0]  q_func,
	input  wire logic [$clog2(MAX_SETS)-1:0] q_set,
	input  wire logic [63:0] q_tag,
	output logic             q_take,
	input  wire logic [3:0]  ways_in_use,
	output logic             res_valid,
	output out_word_t        res_word,
	input  wire logic        res_take
);
	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAYW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	// a row: valid bits, tags and stamps of all ways of one set
	localparam int ROWW = MAX_WAYS * 129;

	bk_state_t state_q, state_d;
	logic [SW-1:0] clr_q;
	logic [SW-1:0] set_s1;
	logic [1:0]    func_s1;
	logic [63:0]   tag_s1;
	logic [63:0]   clock_q;
	logic [31:0]   hit_tot_q, miss_tot_q, evt_tot_q;
	logic          res_full_q;
	logic [ROWW-1:0] rd_row, wr_row;
	logic          ram_we;
	logic [SW-1:0] ram_waddr, ram_raddr;
	logic [MAX_WAYS-1:0] vld;
	logic [63:0]   tg [MAX_WAYS];
	logic [63:0]   st [MAX_WAYS];
	logic [4:0]    ways_eff;
	logic          hit;
	logic [WAYW-1:0] hit_w, free_w, old_w, pick_w;
	logic          free_f, old_f;
	logic [1:0]    hits_c;
	logic          miss_c, evt_c, act_c;

	salt_ram #(.WIDTH(ROWW), .DEPTH(1 << SW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wr_row),
		.raddr(ram_raddr), .rdata(rd_row)
	);

	always_comb begin
		ways_eff = (ways_in_use == 4'd0) ? 5'd1 : {1'b0, ways_in_use};
		if (int'(ways_eff) > MAX_WAYS) ways_eff = 5'(MAX_WAYS);
		hit = 1'b0; hit_w = '0; free_f = 1'b0; free_w = '0; old_f = 1'b0; old_w = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			vld[w] = rd_row[w*129 + 128];
			tg[w] = rd_row[w*129 + 64 +: 64];
			st[w] = rd_row[w*129 +: 64];
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < int'(ways_eff)) begin
				if (vld[w]) begin
					if (tg[w] == tag_s1) begin
						if (!hit) begin hit = 1'b1; hit_w = WAYW'(w); end
					end else if (!old_f || st[w] < st[old_w]) begin
						old_f = 1'b1; old_w = WAYW'(w);
					end
				end else if (!free_f) begin
					free_f = 1'b1; free_w = WAYW'(w);
				end
			end
		end
		act_c = (func_s1 != FUNC_FETCH);
		miss_c = act_c && !hit;
		evt_c = miss_c && !free_f;
		hits_c = 2'(func_s1 == FUNC_MODIFY) + 2'(act_c && hit);
		pick_w = hit ? hit_w : (free_f ? free_w : old_w);
		wr_row = rd_row;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAYW'(w) == pick_w) begin
				wr_row[w*129 + 128] = 1'b1;
				if (!hit) wr_row[w*129 + 64 +: 64] = tag_s1;
				wr_row[w*129 +: 64] = clock_q;
			end
		end
		if (state_q == BK_CLEAR) wr_row = '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: if (clr_q == SW'((1 << SW) - 1)) state_d = BK_IDLE;
			BK_IDLE:  if (q_valid && !res_full_q) state_d = BK_READ;
			BK_READ:  state_d = BK_WRITE;
			BK_WRITE: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// outputs; the row read stays on the taken set until write-back
	always_comb begin
		q_take = 1'b0;
		ram_we = 1'b0;
		ram_waddr = set_s1;
		ram_raddr = set_s1;
		case (state_q)
			BK_CLEAR: begin ram_we = 1'b1; ram_waddr = clr_q; end
			BK_IDLE: begin
				q_take = q_valid && !res_full_q;
				ram_raddr = q_set;
			end
			BK_READ:  ;
			BK_WRITE: ram_we = act_c;
			default:  ;
		endcase
	end

	assign res_valid = res_full_q;

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_take) begin
			set_s1 <= q_set;
			func_s1 <= q_func;
			tag_s1 <= q_tag;
		end
		if (state_q == BK_WRITE) begin
			res_word.hits_added <= hits_c;
			res_word.was_miss <= miss_c;
			res_word.was_eviction <= evt_c;
			res_word.total_hits <= hit_tot_q + 32'(hits_c);
			res_word.total_misses <= miss_tot_q + 32'(miss_c);
			res_word.total_evictions <= evt_tot_q + 32'(evt_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q <= '0;
			clock_q <= '0;
			hit_tot_q <= '0;
			miss_tot_q <= '0;
			evt_tot_q <= '0;
			res_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == BK_WRITE) begin
				res_full_q <= 1'b1;
				hit_tot_q <= hit_tot_q + 32'(hits_c);
				miss_tot_q <= miss_tot_q + 32'(miss_c);
				evt_tot_q <= evt_tot_q + 32'(evt_c);
				if (act_c) clock_q <= clock_q + 64'd1;
			end else if (res_take) begin
				res_full_q <= 1'b0;
			end
		end
	end

	`SALT_ASSERT_IMP(a_take_idle, clk, arst_n, q_take, (state_q == BK_IDLE && !res_full_q), "take outside idle")
	`SALT_ASSERT_NXT(a_write_fills, clk, arst_n, state_q == BK_WRITE, res_full_q, "result lost")
	`SALT_ASSERT_IMP(a_hit_nomiss, clk, arst_n, state_q == BK_WRITE && miss_c, !hit, "miss with hit")
endmodule
`default_nettype wire

### dv/set_assoc_cache_lru_tracker_checker.sv
// Checker for the cache LRU tracker: predicts each result word and compares.
// Depends on salt_pkg; config writes are mirrored from the write port.
`timescale 1ns / 1ps
module set_assoc_cache_lru_tracker_checker
	import salt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  in_word_t   in_word,
	input  logic       empty,
	input  logic       pop,
	input  out_word_t  out_word,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	output int         fail_count,
	output int         pending
);
	localparam int NSETS = MAX_SETS_D;
	localparam int NWAYS = MAX_WAYS_D;

	logic        valid_q [NSETS*NWAYS];
	logic [63:0] tag_q   [NSETS*NWAYS];
	logic [63:0] stamp_q [NSETS*NWAYS];
	logic [63:0] clock_q;
	logic [31:0] hits_q, misses_q, evicts_q;
	logic [2:0]  set_bits_q;
	logic [4:0]  blk_bits_q;
	logic [3:0]  ways_q;
	out_word_t   expected_words[$];

	assign pending = expected_words.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic out_word_t lookup_access(input in_word_t w);
		out_word_t   r;
		int          s, b, nw, base, hit_way, free_way, old_way, k;
		logic [63:0] set_idx, tag;
		r = '0;
		if (w.func != FUNC_FETCH) begin
			s = set_bits_q;
			while (s > 0 && (1 << s) > NSETS) s--;
			b = blk_bits_q;
			nw = ways_q == 0 ? 1 : (ways_q > NWAYS ? NWAYS : ways_q);
			set_idx = (w.mem_address >> b) & ((64'd1 << s) - 1);
			tag = (s + b >= 64) ? 64'd0 : w.mem_address >> (s + b);
			base = (set_idx % NSETS) * NWAYS;
			hit_way = -1; free_way = -1; old_way = -1;
			if (w.func == FUNC_MODIFY) r.hits_added = 1;
			for (int i = 0; i < nw; i++) begin
				k = base + i;
				if (valid_q[k]) begin
					if (tag_q[k] == tag) begin
						if (hit_way < 0) hit_way = i;
					end else if (old_way < 0 || stamp_q[k] < stamp_q[base + old_way]) begin
						old_way = i;
					end
				end else if (free_way < 0) begin
					free_way = i;
				end
			end
			if (hit_way >= 0) begin
				stamp_q[base + hit_way] = clock_q;
				r.hits_added++;
			end else begin
				r.was_miss = 1;
				if (free_way >= 0) begin
					k = base + free_way;
				end else begin
					k = base + (old_way >= 0 ? old_way : 0);
					r.was_eviction = 1;
				end
				valid_q[k] = 1;
				tag_q[k] = tag;
				stamp_q[k] = clock_q;
			end
			clock_q++;
			hits_q += r.hits_added;
			misses_q += r.was_miss;
			evicts_q += r.was_eviction;
		end
		r.total_hits = hits_q;
		r.total_misses = misses_q;
		r.total_evictions = evicts_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			for (int i = 0; i < NSETS*NWAYS; i++) valid_q[i] = 0;
			clock_q = 0; hits_q = 0; misses_q = 0; evicts_q = 0;
			set_bits_q = 0; blk_bits_q = 0; ways_q = 1;
			expected_words.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SET_BITS: set_bits_q = cfg_data[2:0];
					REG_BLK_BITS: blk_bits_q = cfg_data;
					REG_WAYS:     ways_q = cfg_data[3:0];
					default: ;
				endcase
			end
			if (push && !full) expected_words.push_back(lookup_access(in_word));
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					e = expected_words.pop_front();
					if (out_word.hits_added !== e.hits_added)
						report("hits_added", out_word.hits_added, e.hits_added);
					if (out_word.was_miss !== e.was_miss)
						report("was_miss", out_word.was_miss, e.was_miss);
					if (out_word.was_eviction !== e.was_eviction)
						report("was_eviction", out_word.was_eviction, e.was_eviction);
					if (out_word.total_hits !== e.total_hits)
						report("total_hits", out_word.total_hits, e.total_hits);
					if (out_word.total_misses !== e.total_misses)
						report("total_misses", out_word.total_misses, e.total_misses);
					if (out_word.total_evictions !== e.total_evictions)
						report("total_evictions", out_word.total_evictions, e.total_evictions);
				end
			end
		end
	end
endmodule

### dv/set_assoc_cache_lru_tracker_top_tb.sv
// Testbench top for the cache LRU tracker: clock, reset, stimulus, verdict.
// Depends on salt_pkg, set_assoc_cache_lru_tracker_top and the checker.
`timescale 1ns / 1ps
module set_assoc_cache_lru_tracker_top_tb;
	import salt_pkg::*;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       push = 0;
	logic       full;
	in_word_t   in_word = '0;
	logic       empty;
	logic       pop = 0;
	out_word_t  out_word;
	logic       cfg_we = 0;
	logic [1:0] cfg_index = REG_SET_BITS;
	logic [4:0] cfg_data = '0;
	int         fail_count;
	int         pending;
	bit         pop_busy = 0;   // unused flag; calm drives the no-idle stretch on the result side
	bit         calm = 0;

	always #4 clk = ~clk;

	set_assoc_cache_lru_tracker_top i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	set_assoc_cache_lru_tracker_checker i_chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// result side: random stalls, none while calm is set
	always @(posedge clk) begin
		if (arst_n) pop <= calm ? 1'b1 : ($urandom_range(99) >= 33);
	end

	// hold push until full is seen low; random gaps before each word unless calm is set.
	// push stays high after return so back-to-back words need no gap.
	task automatic send_word(input logic [1:0] f, input logic [63:0] a);
		while (!calm && $urandom_range(99) < 33) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		in_word <= '{func: f, mem_address: a};
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// stop pushing, wait for all words out, then let the bench idle before going on
	task automatic drain;
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// addresses from a small pool of tags so hits and evictions both happen
	function automatic logic [63:0] pick_addr(input int sb, input int bb);
		logic [63:0] a;
		a = {$urandom, $urandom};
		if ($urandom_range(9) < 8) begin
			a = a & ((64'd1 << (bb + sb)) - 1);
			a = a | (64'($urandom_range(11)) << (sb + bb));
			if ($urandom_range(3) == 0) a = a | 64'hF000_0000_0000_0000;
		end
		return a;
	endfunction

	initial begin
		int sb, bb, wy;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default config, fetch, modify, extremes of address
		send_word(FUNC_FETCH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(2'd1, 64'd0);
		send_word(2'd2, 64'd0);
		send_word(FUNC_MODIFY, 64'd0);
		send_word(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(FUNC_FETCH, 64'd5);
		drain();
		// too many set bits, big offset, ways above max and zero
		write_reg(REG_SET_BITS, 5'd7);
		write_reg(REG_BLK_BITS, 5'd31);
		write_reg(REG_WAYS, 5'd15);
		for (int i = 0; i < 10; i++)
			send_word(2'(1 + i % 3), {32'(i), 32'hFFFF_FFFF});
		drain();
		write_reg(REG_WAYS, 5'd0);
		write_reg(REG_BLK_BITS, 5'd0);
		write_reg(REG_SET_BITS, 5'd0);
		send_word(2'd1, 64'd1);
		send_word(2'd1, 64'd2);
		send_word(2'd1, 64'd1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 25; ph++) begin
			calm = (ph == 12);
			sb = (ph % 5 == 0) ? 6 : $urandom_range(7);
			bb = (ph % 7 == 0) ? 16 : $urandom_range(6);
			wy = (ph % 4 == 0) ? 8 : $urandom_range(15);
			write_reg(REG_SET_BITS, 5'(sb));
			write_reg(REG_BLK_BITS, 5'(bb));
			write_reg(REG_WAYS, 5'(wy));
			for (int i = 0; i < 50; i++)
				send_word(2'($urandom_range(3)), pick_addr(sb > 6 ? 6 : sb, bb));
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("set_assoc_cache_lru_tracker_top test passed");
		else
			$display("set_assoc_cache_lru_tracker_top test failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("set_assoc_cache_lru_tracker_top test failed");
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/salt_pkg.sv
rtl/core/salt_ram.sv
rtl/core/salt_front.sv
rtl/core/salt_back.sv
rtl/core/set_assoc_cache_lru_tracker_top.sv
dv/set_assoc_cache_lru_tracker_checker.sv
dv/set_assoc_cache_lru_tracker_top_tb.sv
